/* design/lcgn_pkg.sv */
// ----------------------------------------------------------------------------
// lcgn_pkg - shared types and constants of the LCG gaussian noise generator
// Lehmer generator constants, payload structs and word widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgn_pkg;

	localparam int unsigned VALUE_W = 31;
	localparam int unsigned MULT_W  = 15;
	localparam int unsigned FRAC_W  = 24;
	localparam int unsigned SUM_W   = 28;   // twelve 24-bit numerators
	localparam int unsigned DIFF_W  = 29;   // sum minus 6.0, signed
	localparam int unsigned Q_W     = 32;
	localparam int unsigned CNT_W   = 5;

	localparam logic [VALUE_W-1:0] MODULUS = 31'h7FFF_FFFF;
	localparam logic [MULT_W-1:0]  MULT_A  = 15'd24112;
	localparam logic [MULT_W-1:0]  MULT_B  = 15'd26143;

	// last mulmod pass index per request: two passes per advance
	localparam logic [CNT_W-1:0] LAST_UNIFORM = 5'd1;
	localparam logic [CNT_W-1:0] LAST_GAUSS   = 5'd23;

	// 6.0 as a sum of 2^-24 fractions
	localparam logic [SUM_W-1:0] SIX_OFFSET = 28'd6 << FRAC_W;

	localparam logic OP_UNIFORM = 1'b0;
	localparam logic OP_GAUSS   = 1'b1;

	typedef struct packed {
		logic              op;
		logic signed [31:0] mean;
		logic [31:0]        deviation;
	} in_item_t;

	typedef struct packed {
		logic [FRAC_W-1:0]  uniform_fraction;
		logic signed [31:0] gauss_sample;
	} out_item_t;

endpackage

`default_nettype wire

/* design/lcgn_mulmod.sv */
// ----------------------------------------------------------------------------
// lcgn_mulmod - shared modular multiplier
// value * constant mod 2^31-1, constant A or B, Mersenne fold and one
// conditional subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgn_mulmod (
	input  wire logic [lcgn_pkg::VALUE_W-1:0] value,
	input  wire logic                         sel_b,
	output logic      [lcgn_pkg::VALUE_W-1:0] result
);

	localparam int unsigned PROD_W = lcgn_pkg::VALUE_W + lcgn_pkg::MULT_W;

	logic [lcgn_pkg::MULT_W-1:0]  mult;
	logic [PROD_W-1:0]            prod;
	logic [lcgn_pkg::VALUE_W:0]   fold;

	assign mult = sel_b ? lcgn_pkg::MULT_B : lcgn_pkg::MULT_A;
	assign prod = PROD_W'(value) * PROD_W'(mult);

	// 2^31 == 1 mod M: add the high part into the low part
	assign fold = {1'b0, prod[lcgn_pkg::VALUE_W-1:0]}
		+ (lcgn_pkg::VALUE_W + 1)'(prod[PROD_W-1:lcgn_pkg::VALUE_W]);

	// fold < 2M, so one subtract is enough
	always_comb begin
		if (fold >= {1'b0, lcgn_pkg::MODULUS}) begin
			result = lcgn_pkg::VALUE_W'(fold - {1'b0, lcgn_pkg::MODULUS});
		end else begin
			result = fold[lcgn_pkg::VALUE_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* design/lcgn_scale.sv */
// ----------------------------------------------------------------------------
// lcgn_scale - gaussian scale, round and offset
// Registers diff * deviation, then rounds to Q16.16, adds the mean and
// saturates to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgn_scale (
	input  wire logic                               clk,
	input  wire logic                               load,
	input  wire logic signed [lcgn_pkg::DIFF_W-1:0] diff,
	input  wire logic        [lcgn_pkg::Q_W-1:0]    deviation,
	input  wire logic signed [lcgn_pkg::Q_W-1:0]    mean,
	output logic signed      [lcgn_pkg::Q_W-1:0]    gauss
);

	localparam int unsigned PROD_W = lcgn_pkg::DIFF_W + lcgn_pkg::Q_W + 1;
	localparam int unsigned RND_W  = PROD_W - lcgn_pkg::FRAC_W;
	localparam int unsigned RES_W  = RND_W + 1;

	logic signed [lcgn_pkg::Q_W:0] dev_s;
	logic signed [PROD_W-1:0]      prod_d;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [lcgn_pkg::Q_W-1:0] mean_q;
	logic signed [PROD_W-1:0]      rnd;
	logic signed [RES_W-1:0]       res;
	logic signed [RES_W-1:0]       sat_max;
	logic signed [RES_W-1:0]       sat_min;

	assign dev_s  = {1'b0, deviation};
	assign prod_d = diff * dev_s;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= prod_d;
			mean_q <= mean;
		end
	end

	// round half up, then floor by arithmetic shift
	assign rnd = prod_q + PROD_W'(64'sd1 <<< (lcgn_pkg::FRAC_W - 1));
	assign res = {rnd[PROD_W-1], rnd[PROD_W-1:lcgn_pkg::FRAC_W]}
		+ {{(RES_W - lcgn_pkg::Q_W){mean_q[lcgn_pkg::Q_W-1]}}, mean_q};

	assign sat_max = {{(RES_W - lcgn_pkg::Q_W + 1){1'b0}}, {(lcgn_pkg::Q_W - 1){1'b1}}};
	assign sat_min = {{(RES_W - lcgn_pkg::Q_W + 1){1'b1}}, {(lcgn_pkg::Q_W - 1){1'b0}}};

	always_comb begin
		if (res > sat_max) begin
			gauss = sat_max[lcgn_pkg::Q_W-1:0];
		end else if (res < sat_min) begin
			gauss = sat_min[lcgn_pkg::Q_W-1:0];
		end else begin
			gauss = res[lcgn_pkg::Q_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* design/lcg_gaussian_noise_generator.sv */
// ----------------------------------------------------------------------------
// lcg_gaussian_noise_generator - Lehmer LCG noise source
// Uniform or sum-of-twelve gaussian samples from a 31-bit generator.
// ----------------------------------------------------------------------------
// Usage
//   in channel  (in_valid/in_ready/in_data): one request per sample. op 0
//     asks for a uniform sample, op 1 for a gaussian sample scaled by
//     deviation and offset by mean (Q16.16).
//   out channel (out_valid/out_ready/out_data): one result per request,
//     held in an output register until taken.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): loads the generator value;
//     write only while no request is in flight. cfg_ready is always high.
// Sequence
//   Every advance is two passes of the shared mulmod unit, one per cycle.
//   op 0: one advance, then the output state loads the output register.
//   op 1: 24 mulmod passes, then the scale state registers the multiply,
//     then the output state loads the output register.
//   in_ready is high only while the sequencer is idle.
// Reset: generator value 1, sequencer idle, output register empty.
// Stall: a held result keeps the sequencer in its output state; no new
//   request is taken until the result has moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_gaussian_noise_generator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire lcgn_pkg::in_item_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output lcgn_pkg::out_item_t                    out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lcgn_pkg::VALUE_W-1:0]      cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_STEP   = 4'b0010,
		ST_SCALE  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                           state_q;
	logic [lcgn_pkg::VALUE_W-1:0]     gen_q;
	logic [lcgn_pkg::CNT_W-1:0]       cnt_q;
	logic [lcgn_pkg::SUM_W-1:0]       sum_q;
	logic [lcgn_pkg::FRAC_W-1:0]      frac_q;
	lcgn_pkg::in_item_t               req_q;
	logic                             out_valid_q;
	lcgn_pkg::out_item_t              out_q;

	logic [lcgn_pkg::VALUE_W-1:0]     mm_res;
	logic [lcgn_pkg::FRAC_W-1:0]      frac_new;
	logic [lcgn_pkg::CNT_W-1:0]       last_cnt;
	logic signed [lcgn_pkg::DIFF_W-1:0] diff;
	logic signed [lcgn_pkg::Q_W-1:0]  gauss;
	logic                             in_acc;
	logic                             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// even pass multiplies by A, odd pass by B and completes an advance
	lcgn_mulmod u_mulmod (
		.value  (gen_q),
		.sel_b  (cnt_q[0]),
		.result (mm_res)
	);

	assign frac_new = {mm_res[lcgn_pkg::VALUE_W-1:8], 1'b1};
	assign last_cnt = (req_q.op == lcgn_pkg::OP_GAUSS) ? lcgn_pkg::LAST_GAUSS
		: lcgn_pkg::LAST_UNIFORM;

	// sum minus 6.0, in 2^-24 units
	assign diff = $signed({1'b0, sum_q}) - $signed({1'b0, lcgn_pkg::SIX_OFFSET});

	lcgn_scale u_scale (
		.clk       (clk),
		.load      (state_q == ST_SCALE),
		.diff      (diff),
		.deviation (req_q.deviation),
		.mean      (req_q.mean),
		.gauss     (gauss)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == last_cnt) begin
						state_q <= (req_q.op == lcgn_pkg::OP_GAUSS) ? ST_SCALE : ST_FINISH;
					end
				end
				ST_SCALE: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// generator value: loaded by cfg, advanced by each mulmod pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= lcgn_pkg::VALUE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			gen_q <= cfg_data;
		end else if (state_q == ST_STEP) begin
			gen_q <= mm_res;
		end
	end

	// request capture and uniform accumulation
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= in_data;
			sum_q <= '0;
		end else if (state_q == ST_STEP && cnt_q[0]) begin
			frac_q <= frac_new;
			sum_q  <= sum_q + lcgn_pkg::SUM_W'(frac_new);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_q.uniform_fraction <= frac_q;
			out_q.gauss_sample     <= (req_q.op == lcgn_pkg::OP_GAUSS) ? gauss : '0;
		end
	end

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request taken while busy");

	a_step_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && !cfg_valid) |=> (gen_q != lcgn_pkg::MODULUS))
		else $error("mulmod result not reduced");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (cnt_q <= lcgn_pkg::LAST_GAUSS))
		else $error("pass counter overran");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("result not registered");

	a_frac_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.uniform_fraction[0])
		else $error("uniform numerator not odd");

endmodule

`default_nettype wire
